// ===== hw/rtl/source_text_tokenizer_top_defines.svh =====
`ifndef SOURCE_TEXT_TOKENIZER_TOP_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define STT_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// next-cycle implication, sampled on clk, off during reset
`define STT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

// ===== hw/rtl/stt_pkg.sv =====
`default_nettype none

package stt_pkg;

    localparam int LINE_BITS = 16;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_IDENT   = 4'd1,
        M_NUMBER  = 4'd2,
        M_STRING  = 4'd3,
        M_ESCAPE  = 4'd4,
        M_COMMENT = 4'd5,
        M_BANG    = 4'd6,
        M_QUEST   = 4'd7,
        M_LESS    = 4'd8,
        M_GREATER = 4'd9,
        M_ERROR   = 4'd10
    } mode_t;

    localparam logic [1:0] KIND_TEXT  = 2'd0;
    localparam logic [1:0] KIND_TOKEN = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic ERR_UNEXPECTED   = 1'b0;
    localparam logic ERR_UNTERMINATED = 1'b1;

    localparam logic [4:0] TT_IDENT    = 5'd0;
    localparam logic [4:0] TT_NUMBER   = 5'd1;
    localparam logic [4:0] TT_STRING   = 5'd2;
    localparam logic [4:0] TT_PLUS     = 5'd3;
    localparam logic [4:0] TT_MINUS    = 5'd4;
    localparam logic [4:0] TT_STAR     = 5'd5;
    localparam logic [4:0] TT_SLASH    = 5'd6;
    localparam logic [4:0] TT_LPAREN   = 5'd7;
    localparam logic [4:0] TT_RPAREN   = 5'd8;
    localparam logic [4:0] TT_COMMA    = 5'd9;
    localparam logic [4:0] TT_LBRACE   = 5'd10;
    localparam logic [4:0] TT_RBRACE   = 5'd11;
    localparam logic [4:0] TT_LBRACKET = 5'd12;
    localparam logic [4:0] TT_RBRACKET = 5'd13;
    localparam logic [4:0] TT_ASSIGN   = 5'd14;
    localparam logic [4:0] TT_NEQ      = 5'd15;
    localparam logic [4:0] TT_EQ       = 5'd16;
    localparam logic [4:0] TT_LT       = 5'd17;
    localparam logic [4:0] TT_LTE      = 5'd18;
    localparam logic [4:0] TT_GT       = 5'd19;
    localparam logic [4:0] TT_GTE      = 5'd20;
    localparam logic [4:0] TT_EOF      = 5'd21;

    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_BANG      = 8'h21;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_LESS      = 8'h3C;
    localparam logic [7:0] CH_EQUAL     = 8'h3D;
    localparam logic [7:0] CH_GREATER   = 8'h3E;
    localparam logic [7:0] CH_QUEST     = 8'h3F;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_TILDE     = 8'h7E;
    localparam logic [7:0] CH_NUL       = 8'h00;

    typedef struct packed {
        logic [7:0] byte_req;
        logic       end_of_input;
    } byte_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  token_type;
        logic [7:0]  text_char;
        logic        error_code;
        logic [15:0] line_number;
        logic        last;
    } token_item_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c inside {CH_SPACE, [CH_TAB:CH_CR]});
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {[CH_LOWER_A:CH_LOWER_Z], [CH_UPPER_A:CH_UPPER_Z]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {[CH_ZERO:CH_NINE]});
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return (c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LPAREN, CH_RPAREN,
                          CH_COMMA, CH_LBRACE, CH_RBRACE, CH_LBRACKET, CH_RBRACKET,
                          CH_EQUAL});
    endfunction

    function automatic logic [4:0] op_type(input logic [7:0] c);
        logic [4:0] t;
        case (c)
            CH_PLUS:     t = TT_PLUS;
            CH_MINUS:    t = TT_MINUS;
            CH_STAR:     t = TT_STAR;
            CH_SLASH:    t = TT_SLASH;
            CH_LPAREN:   t = TT_LPAREN;
            CH_RPAREN:   t = TT_RPAREN;
            CH_COMMA:    t = TT_COMMA;
            CH_LBRACE:   t = TT_LBRACE;
            CH_RBRACE:   t = TT_RBRACE;
            CH_LBRACKET: t = TT_LBRACKET;
            CH_RBRACKET: t = TT_RBRACKET;
            default:     t = TT_ASSIGN;
        endcase
        return t;
    endfunction

    function automatic token_item_t mk_tok(input logic [1:0] kind, input logic [4:0] tt,
                                           input logic [7:0] ch, input logic err);
        token_item_t r;
        r.kind        = kind;
        r.token_type  = tt;
        r.text_char   = ch;
        r.error_code  = err;
        r.line_number = '0;
        r.last        = 1'b0;
        return r;
    endfunction

    function automatic mode_t start_mode(input logic [7:0] c);
        mode_t m;
        if (is_space(c) || is_op(c))
        begin
            m = M_IDLE;
        end
        else if (is_alpha(c) || c == CH_UNDERSCORE)
        begin
            m = M_IDENT;
        end
        else if (is_digit(c))
        begin
            m = M_NUMBER;
        end
        else
        begin
            case (c)
                CH_TILDE:   m = M_COMMENT;
                CH_BANG:    m = M_BANG;
                CH_QUEST:   m = M_QUEST;
                CH_LESS:    m = M_LESS;
                CH_GREATER: m = M_GREATER;
                CH_QUOTE:   m = M_STRING;
                default:    m = M_ERROR;
            endcase
        end
        return m;
    endfunction

    function automatic logic start_has(input logic [7:0] c);
        mode_t m;
        m = start_mode(c);
        return is_op(c) || m == M_IDENT || m == M_NUMBER || m == M_ERROR;
    endfunction

    function automatic token_item_t start_tok(input logic [7:0] c);
        token_item_t r;
        if (is_alpha(c) || c == CH_UNDERSCORE)
        begin
            r = mk_tok(KIND_TEXT, TT_IDENT, c, 1'b0);
        end
        else if (is_digit(c))
        begin
            r = mk_tok(KIND_TEXT, TT_NUMBER, c, 1'b0);
        end
        else if (is_op(c))
        begin
            r = mk_tok(KIND_TOKEN, op_type(c), CH_NUL, 1'b0);
        end
        else
        begin
            r = mk_tok(KIND_ERROR, TT_IDENT, c, ERR_UNEXPECTED);
        end
        return r;
    endfunction

    function automatic logic [15:0] line_out(input logic [LINE_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[15:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/source_text_tokenizer_top.sv =====
// A request is registered at acceptance; its first result is registered when the request advances.
// Throughput: one request per cycle while each gives at most one result and token_stall is low;
// the two-result buffer drains one result per cycle; a second result holds the next request back.
// Reset: rst_n clears the lexing mode to idle, the line counter to one, and both buffers
// to empty; an end marker returns the mode and the line counter to the same values.
`default_nettype none
module source_text_tokenizer_top (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          byte_valid,
    output logic                         byte_stall,
    input  stt_pkg::byte_item_t          byte_item,
    output logic                         token_valid,
    input  wire                          token_stall,
    output stt_pkg::token_item_t         token_item
);

    stt_pkg::byte_item_t              item_reg;
    logic                             item_valid_reg;
    stt_pkg::mode_t                   mode_reg;
    stt_pkg::mode_t                   mode_next;
    logic [stt_pkg::LINE_BITS-1:0]    line_reg;
    logic [stt_pkg::LINE_BITS-1:0]    line_next;
    stt_pkg::token_item_t             res0_reg;
    stt_pkg::token_item_t             res1_reg;
    logic [1:0]                       cnt_reg;

    stt_pkg::token_item_t             r0;
    stt_pkg::token_item_t             r1;
    logic [1:0]                       n;
    logic [7:0]                       c;
    logic                             fin;
    logic                             pop;
    logic                             advance;
    logic                             take;

    assign c           = item_reg.byte_req;
    assign fin         = item_reg.end_of_input || c == stt_pkg::CH_NUL;
    assign token_valid = cnt_reg != 2'd0;
    assign token_item  = res0_reg;
    assign pop         = token_valid && !token_stall;
    assign advance     = item_valid_reg && (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop));
    assign byte_stall  = item_valid_reg && !advance;
    assign take        = byte_valid && !byte_stall;

    always_comb
    begin
        mode_next = mode_reg;
        line_next = line_reg;
        if (fin)
        begin
            mode_next = stt_pkg::M_IDLE;
            line_next = stt_pkg::LINE_BITS'(1);
        end
        else if (mode_reg != stt_pkg::M_ERROR)
        begin
            case (mode_reg)
                stt_pkg::M_IDENT:
                begin
                    if (!(stt_pkg::is_alpha(c) || stt_pkg::is_digit(c)
                          || c == stt_pkg::CH_UNDERSCORE))
                    begin
                        mode_next = stt_pkg::start_mode(c);
                    end
                end
                stt_pkg::M_NUMBER:
                begin
                    if (!(stt_pkg::is_digit(c) || c == stt_pkg::CH_DOT))
                    begin
                        mode_next = stt_pkg::start_mode(c);
                    end
                end
                stt_pkg::M_STRING:
                begin
                    if (c == stt_pkg::CH_QUOTE)
                    begin
                        mode_next = stt_pkg::M_IDLE;
                    end
                    else if (c == stt_pkg::CH_BACKSLASH)
                    begin
                        mode_next = stt_pkg::M_ESCAPE;
                    end
                end
                stt_pkg::M_ESCAPE:
                begin
                    mode_next = stt_pkg::M_STRING;
                end
                stt_pkg::M_COMMENT:
                begin
                    if (c == stt_pkg::CH_LF)
                    begin
                        mode_next = stt_pkg::M_IDLE;
                    end
                end
                stt_pkg::M_BANG, stt_pkg::M_QUEST:
                begin
                    mode_next = (c == stt_pkg::CH_EQUAL) ? stt_pkg::M_IDLE : stt_pkg::M_ERROR;
                end
                stt_pkg::M_LESS, stt_pkg::M_GREATER:
                begin
                    mode_next = (c == stt_pkg::CH_EQUAL) ? stt_pkg::M_IDLE
                                                         : stt_pkg::start_mode(c);
                end
                default:
                begin
                    mode_next = stt_pkg::start_mode(c);
                end
            endcase
            if (c == stt_pkg::CH_LF && line_reg != '1)
            begin
                line_next = line_reg + stt_pkg::LINE_BITS'(1);
            end
        end
    end

    always_comb
    begin
        r0 = stt_pkg::mk_tok(stt_pkg::KIND_TOKEN, stt_pkg::TT_EOF, stt_pkg::CH_NUL, 1'b0);
        r1 = r0;
        n  = 2'd0;
        if (fin)
        begin
            case (mode_reg)
                stt_pkg::M_ERROR:
                begin
                    n = 2'd0;
                end
                stt_pkg::M_STRING, stt_pkg::M_ESCAPE:
                begin
                    r0 = stt_pkg::mk_tok(stt_pkg::KIND_ERROR, stt_pkg::TT_IDENT,
                                         stt_pkg::CH_NUL, stt_pkg::ERR_UNTERMINATED);
                    n  = 2'd1;
                end
                stt_pkg::M_BANG:
                begin
                    r0 = stt_pkg::mk_tok(stt_pkg::KIND_ERROR, stt_pkg::TT_IDENT,
                                         stt_pkg::CH_BANG, stt_pkg::ERR_UNEXPECTED);
                    n  = 2'd1;
                end
                stt_pkg::M_QUEST:
                begin
                    r0 = stt_pkg::mk_tok(stt_pkg::KIND_ERROR, stt_pkg::TT_IDENT,
                                         stt_pkg::CH_QUEST, stt_pkg::ERR_UNEXPECTED);
                    n  = 2'd1;
                end
                stt_pkg::M_IDENT:
                begin
                    r0 = stt_pkg::mk_tok(stt_pkg::KIND_TOKEN, stt_pkg::TT_IDENT,
                                         stt_pkg::CH_NUL, 1'b0);
                    n  = 2'd2;
                end
                stt_pkg::M_NUMBER:
                begin
                    r0 = stt_pkg::mk_tok(stt_pkg::KIND_TOKEN, stt_pkg::TT_NUMBER,
                                         stt_pkg::CH_NUL, 1'b0);
                    n  = 2'd2;
                end
                stt_pkg::M_LESS:
                begin
                    r0 = stt_pkg::mk_tok(stt_pkg::KIND_TOKEN, stt_pkg::TT_LT,
                                         stt_pkg::CH_NUL, 1'b0);
                    n  = 2'd2;
                end
                stt_pkg::M_GREATER:
                begin
                    r0 = stt_pkg::mk_tok(stt_pkg::KIND_TOKEN, stt_pkg::TT_GT,
                                         stt_pkg::CH_NUL, 1'b0);
                    n  = 2'd2;
                end
                default:
                begin
                    n = 2'd1;
                end
            endcase
        end
        else if (mode_reg != stt_pkg::M_ERROR)
        begin
            case (mode_reg)
                stt_pkg::M_IDENT:
                begin
                    if (stt_pkg::is_alpha(c) || stt_pkg::is_digit(c)
                        || c == stt_pkg::CH_UNDERSCORE)
                    begin
                        r0 = stt_pkg::mk_tok(stt_pkg::KIND_TEXT, stt_pkg::TT_IDENT, c, 1'b0);
                        n  = 2'd1;
                    end
                    else
                    begin
                        r0 = stt_pkg::mk_tok(stt_pkg::KIND_TOKEN, stt_pkg::TT_IDENT,
                                             stt_pkg::CH_NUL, 1'b0);
                        r1 = stt_pkg::start_tok(c);
                        n  = 2'd1 + 2'(stt_pkg::start_has(c));
                    end
                end
                stt_pkg::M_NUMBER:
                begin
                    if (stt_pkg::is_digit(c) || c == stt_pkg::CH_DOT)
                    begin
                        r0 = stt_pkg::mk_tok(stt_pkg::KIND_TEXT, stt_pkg::TT_NUMBER, c, 1'b0);
                        n  = 2'd1;
                    end
                    else
                    begin
                        r0 = stt_pkg::mk_tok(stt_pkg::KIND_TOKEN, stt_pkg::TT_NUMBER,
                                             stt_pkg::CH_NUL, 1'b0);
                        r1 = stt_pkg::start_tok(c);
                        n  = 2'd1 + 2'(stt_pkg::start_has(c));
                    end
                end
                stt_pkg::M_STRING:
                begin
                    if (c == stt_pkg::CH_QUOTE)
                    begin
                        r0 = stt_pkg::mk_tok(stt_pkg::KIND_TOKEN, stt_pkg::TT_STRING,
                                             stt_pkg::CH_NUL, 1'b0);
                        n  = 2'd1;
                    end
                    else if (c != stt_pkg::CH_BACKSLASH)
                    begin
                        r0 = stt_pkg::mk_tok(stt_pkg::KIND_TEXT, stt_pkg::TT_STRING, c, 1'b0);
                        n  = 2'd1;
                    end
                end
                stt_pkg::M_ESCAPE:
                begin
                    if (c == stt_pkg::CH_LOWER_N)
                    begin
                        r0 = stt_pkg::mk_tok(stt_pkg::KIND_TEXT, stt_pkg::TT_STRING,
                                             stt_pkg::CH_LF, 1'b0);
                    end
                    else if (c == stt_pkg::CH_LOWER_T)
                    begin
                        r0 = stt_pkg::mk_tok(stt_pkg::KIND_TEXT, stt_pkg::TT_STRING,
                                             stt_pkg::CH_TAB, 1'b0);
                    end
                    else
                    begin
                        r0 = stt_pkg::mk_tok(stt_pkg::KIND_TEXT, stt_pkg::TT_STRING, c, 1'b0);
                    end
                    n = 2'd1;
                end
                stt_pkg::M_COMMENT:
                begin
                    n = 2'd0;
                end
                stt_pkg::M_BANG:
                begin
                    r0 = (c == stt_pkg::CH_EQUAL)
                       ? stt_pkg::mk_tok(stt_pkg::KIND_TOKEN, stt_pkg::TT_NEQ,
                                         stt_pkg::CH_NUL, 1'b0)
                       : stt_pkg::mk_tok(stt_pkg::KIND_ERROR, stt_pkg::TT_IDENT,
                                         stt_pkg::CH_BANG, stt_pkg::ERR_UNEXPECTED);
                    n  = 2'd1;
                end
                stt_pkg::M_QUEST:
                begin
                    r0 = (c == stt_pkg::CH_EQUAL)
                       ? stt_pkg::mk_tok(stt_pkg::KIND_TOKEN, stt_pkg::TT_EQ,
                                         stt_pkg::CH_NUL, 1'b0)
                       : stt_pkg::mk_tok(stt_pkg::KIND_ERROR, stt_pkg::TT_IDENT,
                                         stt_pkg::CH_QUEST, stt_pkg::ERR_UNEXPECTED);
                    n  = 2'd1;
                end
                stt_pkg::M_LESS:
                begin
                    if (c == stt_pkg::CH_EQUAL)
                    begin
                        r0 = stt_pkg::mk_tok(stt_pkg::KIND_TOKEN, stt_pkg::TT_LTE,
                                             stt_pkg::CH_NUL, 1'b0);
                        n  = 2'd1;
                    end
                    else
                    begin
                        r0 = stt_pkg::mk_tok(stt_pkg::KIND_TOKEN, stt_pkg::TT_LT,
                                             stt_pkg::CH_NUL, 1'b0);
                        r1 = stt_pkg::start_tok(c);
                        n  = 2'd1 + 2'(stt_pkg::start_has(c));
                    end
                end
                stt_pkg::M_GREATER:
                begin
                    if (c == stt_pkg::CH_EQUAL)
                    begin
                        r0 = stt_pkg::mk_tok(stt_pkg::KIND_TOKEN, stt_pkg::TT_GTE,
                                             stt_pkg::CH_NUL, 1'b0);
                        n  = 2'd1;
                    end
                    else
                    begin
                        r0 = stt_pkg::mk_tok(stt_pkg::KIND_TOKEN, stt_pkg::TT_GT,
                                             stt_pkg::CH_NUL, 1'b0);
                        r1 = stt_pkg::start_tok(c);
                        n  = 2'd1 + 2'(stt_pkg::start_has(c));
                    end
                end
                default:
                begin
                    r0 = stt_pkg::start_tok(c);
                    n  = 2'(stt_pkg::start_has(c));
                end
            endcase
        end
        r0.line_number = stt_pkg::line_out(line_reg);
        r1.line_number = stt_pkg::line_out(line_reg);
        r0.last        = n == 2'd1;
        r1.last        = n == 2'd2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            mode_reg       <= stt_pkg::M_IDLE;
            line_reg       <= stt_pkg::LINE_BITS'(1);
            cnt_reg        <= 2'd0;
        end
        else
        begin
            if (take)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                mode_reg <= mode_next;
                line_reg <= line_next;
                cnt_reg  <= n;
            end
            else if (pop)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= byte_item;
        end
        if (advance)
        begin
            res0_reg <= r0;
            res1_reg <= r1;
        end
        else if (pop)
        begin
            res0_reg <= res1_reg;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/stt_checker.sv =====
`default_nettype none
`include "source_text_tokenizer_top_defines.svh"

module stt_checker (
    input wire                  clk,
    input wire                  rst_n,
    input wire                  byte_valid,
    input wire                  byte_stall,
    input stt_pkg::byte_item_t  byte_item,
    input wire                  token_valid,
    input wire                  token_stall,
    input stt_pkg::token_item_t token_item
);

    logic error_shown;
    logic token_shown;
    logic token_clean;

    assign error_shown = token_valid && token_item.kind == stt_pkg::KIND_ERROR;
    assign token_shown = token_valid && token_item.kind == stt_pkg::KIND_TOKEN;
    assign token_clean = token_item.text_char == stt_pkg::CH_NUL && !token_item.error_code;

    `STT_ASSERT_NEXT(a_hold_result, token_valid && token_stall, token_valid && $stable(token_item))
    `STT_ASSERT_IMPLY(a_request_known, byte_valid, !$isunknown(byte_item))
    `STT_ASSERT_IMPLY(a_error_type_zero, error_shown, token_item.token_type == stt_pkg::TT_IDENT)
    `STT_ASSERT_IMPLY(a_token_no_text, token_shown, token_clean)
    `STT_ASSERT_IMPLY(a_stall_only_when_backed_up, byte_stall, token_valid)

endmodule

bind source_text_tokenizer_top stt_checker u_stt_checker (.*);

`default_nettype wire

// ===== test/tb_source_text_tokenizer_top.sv =====
`timescale 1ns / 1ps

module tb_source_text_tokenizer_top;
    import stt_pkg::*;

    localparam logic [4:0] TT_NONE = 5'd0;
    localparam string LEAD = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    localparam string TAIL = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    localparam string DIGITS = "0123456789";
    localparam string NUM_TAIL = "0123456789.";
    localparam string OPS = "+-*/(),{}[]=";
    localparam string PAIR_LEADS = "!?<>";

    class token_scoreboard;
        mode_t mode;
        logic [LINE_BITS-1:0] lines;
        token_item_t step_q[$];
        token_item_t expected_q[$];
        int mismatches;
        int results_seen;
        int eof_count;
        int error_count;
        int line_peak;

        function new();
            mismatches = 0;
            results_seen = 0;
            eof_count = 0;
            error_count = 0;
            line_peak = 0;
            restart();
        endfunction

        function void restart();
            mode = M_IDLE;
            lines = LINE_BITS'(1);
        endfunction

        function void add(logic [1:0] kind, logic [4:0] tt, logic [7:0] ch, logic err);
            token_item_t r;
            r.kind = kind;
            r.token_type = tt;
            r.text_char = ch;
            r.error_code = err;
            r.line_number = 16'(lines);
            r.last = 1'b0;
            if (step_q.size() < 2)
                step_q.push_back(r);
        endfunction

        function void text(logic [4:0] tt, logic [7:0] c);
            add(KIND_TEXT, tt, c, 1'b0);
        endfunction

        function void done(logic [4:0] tt);
            add(KIND_TOKEN, tt, CH_NUL, 1'b0);
        endfunction

        function void unexpected(logic [7:0] c);
            add(KIND_ERROR, TT_NONE, c, ERR_UNEXPECTED);
            mode = M_ERROR;
        endfunction

        function bit blank(logic [7:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        function bit letter(logic [7:0] c);
            return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
        endfunction

        function bit digit(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function void open_token(logic [7:0] c);
            mode = M_IDLE;
            if (blank(c))
                return;
            if (letter(c) || c == CH_UNDERSCORE)
            begin
                mode = M_IDENT;
                text(TT_IDENT, c);
            end
            else if (digit(c))
            begin
                mode = M_NUMBER;
                text(TT_NUMBER, c);
            end
            else
            begin
                case (c)
                    CH_TILDE:    mode = M_COMMENT;
                    CH_PLUS:     done(TT_PLUS);
                    CH_MINUS:    done(TT_MINUS);
                    CH_STAR:     done(TT_STAR);
                    CH_SLASH:    done(TT_SLASH);
                    CH_LPAREN:   done(TT_LPAREN);
                    CH_RPAREN:   done(TT_RPAREN);
                    CH_COMMA:    done(TT_COMMA);
                    CH_LBRACE:   done(TT_LBRACE);
                    CH_RBRACE:   done(TT_RBRACE);
                    CH_LBRACKET: done(TT_LBRACKET);
                    CH_RBRACKET: done(TT_RBRACKET);
                    CH_EQUAL:    done(TT_ASSIGN);
                    CH_BANG:     mode = M_BANG;
                    CH_QUEST:    mode = M_QUEST;
                    CH_LESS:     mode = M_LESS;
                    CH_GREATER:  mode = M_GREATER;
                    CH_QUOTE:    mode = M_STRING;
                    default:     unexpected(c);
                endcase
            end
        endfunction

        function void take_byte(logic [7:0] c);
            case (mode)
                M_IDENT:
                    if (letter(c) || digit(c) || c == CH_UNDERSCORE)
                        text(TT_IDENT, c);
                    else
                    begin
                        done(TT_IDENT);
                        open_token(c);
                    end
                M_NUMBER:
                    if (digit(c) || c == CH_DOT)
                        text(TT_NUMBER, c);
                    else
                    begin
                        done(TT_NUMBER);
                        open_token(c);
                    end
                M_STRING:
                    if (c == CH_QUOTE)
                    begin
                        done(TT_STRING);
                        mode = M_IDLE;
                    end
                    else if (c == CH_BACKSLASH)
                        mode = M_ESCAPE;
                    else
                        text(TT_STRING, c);
                M_ESCAPE:
                begin
                    if (c == CH_LOWER_N)
                        text(TT_STRING, CH_LF);
                    else if (c == CH_LOWER_T)
                        text(TT_STRING, CH_TAB);
                    else
                        text(TT_STRING, c);
                    mode = M_STRING;
                end
                M_COMMENT:
                    if (c == CH_LF)
                        mode = M_IDLE;
                M_BANG:
                    if (c == CH_EQUAL)
                    begin
                        done(TT_NEQ);
                        mode = M_IDLE;
                    end
                    else
                        unexpected(CH_BANG);
                M_QUEST:
                    if (c == CH_EQUAL)
                    begin
                        done(TT_EQ);
                        mode = M_IDLE;
                    end
                    else
                        unexpected(CH_QUEST);
                M_LESS:
                    if (c == CH_EQUAL)
                    begin
                        done(TT_LTE);
                        mode = M_IDLE;
                    end
                    else
                    begin
                        done(TT_LT);
                        open_token(c);
                    end
                M_GREATER:
                    if (c == CH_EQUAL)
                    begin
                        done(TT_GTE);
                        mode = M_IDLE;
                    end
                    else
                    begin
                        done(TT_GT);
                        open_token(c);
                    end
                default:
                    open_token(c);
            endcase
        endfunction

        function void finish_source();
            case (mode)
                M_ERROR: ;
                M_STRING, M_ESCAPE: add(KIND_ERROR, TT_NONE, CH_NUL, ERR_UNTERMINATED);
                M_BANG:    unexpected(CH_BANG);
                M_QUEST:   unexpected(CH_QUEST);
                M_IDENT:
                begin
                    done(TT_IDENT);
                    done(TT_EOF);
                end
                M_NUMBER:
                begin
                    done(TT_NUMBER);
                    done(TT_EOF);
                end
                M_LESS:
                begin
                    done(TT_LT);
                    done(TT_EOF);
                end
                M_GREATER:
                begin
                    done(TT_GT);
                    done(TT_EOF);
                end
                default:   done(TT_EOF);
            endcase
        endfunction

        // returns 1 when the request is not swallowed by the error mode
        function bit note_byte(byte_item_t it);
            logic [7:0] c;
            bit fin;
            bit live;
            c = it.byte_req;
            fin = it.end_of_input || c == CH_NUL;
            live = fin || mode != M_ERROR;
            step_q.delete();
            if (fin)
            begin
                finish_source();
                restart();
            end
            else if (mode != M_ERROR)
            begin
                take_byte(c);
                if (c == CH_LF && lines != '1)
                    lines = lines + 1'b1;
            end
            if (step_q.size() > 0)
                step_q[step_q.size() - 1].last = 1'b1;
            foreach (step_q[i])
                expected_q.push_back(step_q[i]);
            return live;
        endfunction

        function string fmt(token_item_t t);
            return $sformatf("kind=%0d type=%0d char=%02h err=%0d line=%0d last=%0d",
                             t.kind, t.token_type, t.text_char, t.error_code,
                             t.line_number, t.last);
        endfunction

        task report(string msg);
            mismatches++;
            $display("mismatch: %s", msg);
        endtask

        task check_result(token_item_t got);
            token_item_t want;
            string bad;
            bad = "";
            results_seen++;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result %0d not expected: %s", results_seen, fmt(got)));
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind)
                bad = {bad, " kind"};
            if (got.token_type !== want.token_type)
                bad = {bad, " token_type"};
            if (got.text_char !== want.text_char)
                bad = {bad, " text_char"};
            if (got.error_code !== want.error_code)
                bad = {bad, " error_code"};
            if (got.line_number !== want.line_number)
                bad = {bad, " line_number"};
            if (got.last !== want.last)
                bad = {bad, " last"};
            if (bad.len() > 0)
                report($sformatf("result %0d differs in%s: got %s, want %s",
                                 results_seen, bad, fmt(got), fmt(want)));
            if (want.kind == KIND_TOKEN && want.token_type == TT_EOF)
                eof_count++;
            if (want.kind == KIND_ERROR)
                error_count++;
            if (int'(want.line_number) > line_peak)
                line_peak = int'(want.line_number);
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic byte_valid = 1'b0;
    logic byte_stall;
    byte_item_t byte_item = '0;
    logic token_valid;
    logic token_stall = 1'b0;
    token_item_t token_item;

    bit quiet = 1'b0;
    int sent_bytes = 0;
    int live_bytes = 0;
    token_scoreboard sb = new();

    source_text_tokenizer_top uut (
        .clk(clk),
        .rst_n(rst_n),
        .byte_valid(byte_valid),
        .byte_stall(byte_stall),
        .byte_item(byte_item),
        .token_valid(token_valid),
        .token_stall(token_stall),
        .token_item(token_item)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic logic [7:0] space_char();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
    endfunction

    function automatic logic [7:0] str_char();
        logic [7:0] c;
        if ($urandom_range(0, 2) == 0)
            c = 8'($urandom_range(1, 255));
        else
            c = pick({TAIL, " "});
        if (c == CH_QUOTE || c == CH_BACKSLASH)
            c = CH_LOWER_A;
        return c;
    endfunction

    task automatic send(logic [7:0] b, logic fin);
        byte_item_t it;
        int gap;
        it.byte_req = b;
        it.end_of_input = fin;
        gap = (!quiet && $urandom_range(0, 2) == 0) ? gap_len() : 0;
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item <= it;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        sent_bytes++;
        if (sb.note_byte(it))
            live_bytes++;
    endtask

    task automatic send_text(string s);
        foreach (s[i])
            send(s[i], 1'b0);
    endtask

    task automatic end_source();
        if ($urandom_range(0, 2) == 0)
            send(CH_NUL, 1'b0);
        else
            send(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic gen_segment();
        int r;
        int k;
        int n;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        n = $urandom_range(0, 6);
        if (r < 22)
        begin
            send(pick(LEAD), 1'b0);
            repeat (n) send(pick(TAIL), 1'b0);
        end
        else if (r < 36)
        begin
            send(pick(DIGITS), 1'b0);
            repeat (n) send(pick(NUM_TAIL), 1'b0);
        end
        else if (r < 48)
        begin
            send(CH_QUOTE, 1'b0);
            repeat (n)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    send(CH_BACKSLASH, 1'b0);
                    k = $urandom_range(0, 2);
                    if (k == 0)
                        send(CH_LOWER_N, 1'b0);
                    else if (k == 1)
                        send(CH_LOWER_T, 1'b0);
                    else
                        send(8'($urandom_range(1, 255)), 1'b0);
                end
                else
                    send(str_char(), 1'b0);
            end
            if ($urandom_range(0, 11) != 0)
                send(CH_QUOTE, 1'b0);
        end
        else if (r < 64)
            send(pick(OPS), 1'b0);
        else if (r < 74)
        begin
            c = pick(PAIR_LEADS);
            send(c, 1'b0);
            k = $urandom_range(0, 9);
            if (k < 7 || (k < 9 && (c == CH_BANG || c == CH_QUEST)))
                send(CH_EQUAL, 1'b0);
            else if (k == 9)
                send(8'($urandom_range(1, 255)), 1'b0);
        end
        else if (r < 80)
        begin
            send(CH_TILDE, 1'b0);
            repeat (n)
            begin
                c = 8'($urandom_range(1, 255));
                send((c == CH_LF) ? CH_SPACE : c, 1'b0);
            end
            if ($urandom_range(0, 9) != 0)
                send(CH_LF, 1'b0);
        end
        else if (r < 93)
        begin
            repeat ($urandom_range(1, 3)) send(space_char(), 1'b0);
        end
        else if (r < 95)
            send(8'($urandom_range(1, 255)), 1'b0);
        else
        begin
            end_source();
            quiet = ($urandom_range(0, 4) == 0);
            return;
        end
        if ($urandom_range(0, 1) == 0)
            send(space_char(), 1'b0);
    endtask

    initial
    begin : result_sink
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && token_valid && !token_stall)
                sb.check_result(token_item);
            if (hold == 0 && !quiet && $urandom_range(0, 3) == 0)
                hold = gap_len();
            token_stall <= (hold > 0);
            if (hold > 0)
                hold--;
        end
    end

    initial
    begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("+-*/(),{}[]=");
        send_text("!=?=<=>=");
        send_text("<_>9");
        send(CH_NUL, 1'b0);
        send_text("\"a\\tb\\n\\q\"\"x\\");
        send(8'hFF, 1'b1);
        send(8'h80, 1'b0);
        send_text("q\n");
        send(8'h00, 1'b1);
        send_text("!x");
        end_source();
        send_text("?");
        end_source();
        send_text(">");
        end_source();

        while (sent_bytes < 1330)
            gen_segment();
        end_source();

        quiet = 1'b1;
        send_text("z\n\"s\"~c\n7");
        end_source();
        quiet = 1'b0;
        byte_valid <= 1'b0;

        while (sb.expected_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d source bytes (%0d outside error mode), %0d results checked",
                 sent_bytes, live_bytes, sb.results_seen);
        $display("saw %0d end-of-file tokens, %0d error results, line numbers up to %0d",
                 sb.eof_count, sb.error_count, sb.line_peak);
        if (sb.mismatches == 0)
            $display("tb_source_text_tokenizer_top: PASS");
        else
            $display("tb_source_text_tokenizer_top: FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("tb_source_text_tokenizer_top: FAIL");
        $finish;
    end

endmodule
